// ===== hw/rtl/bdtw_pkg.sv =====
// ============================================================================
// Banded DTW distance package
// Shared sizes, field widths, command codes and the cost sentinel.
// ============================================================================
package bdtw_pkg;

  localparam int MAX_QUERY    = 1024;
  localparam int MAX_TEMPLATE = 1024;

  localparam int QA_W = $clog2(MAX_QUERY);
  localparam int TA_W = $clog2(MAX_TEMPLATE);
  localparam int CA_W = $clog2(3 * MAX_TEMPLATE);
  // Signed width of the band upper edge computation.
  localparam int HW   = ((QA_W > TA_W) ? QA_W : TA_W) + 3;

  localparam int CMD_W      = 2;
  localparam int IDX_W      = 10;
  localparam int SAMPLE_W   = 16;
  localparam int LEN_W      = 11;
  localparam int DIST_W     = 22;
  localparam int POS_W      = 10;
  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 40;

  localparam int COST_W = 32;
  localparam int D_W    = 16;
  localparam int D3_W   = 18;

  localparam logic [COST_W-1:0] SENTINEL = 32'd2560000;

  localparam logic [CMD_W-1:0] CMD_LOAD_QUERY    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LOAD_TEMPLATE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_COMPUTE       = 2'd2;

endpackage

// ===== hw/rtl/bdtw_acc_unit.sv =====
// ============================================================================
// Banded DTW accumulate unit
// Saturating add of a step cost to a neighbor cost, then minimum against the
// running candidate. Shared by all three predecessor terms of a cell.
// ============================================================================
module bdtw_acc_unit import bdtw_pkg::*; (
  input  logic [COST_W-1:0] operand,
  input  logic [D3_W-1:0]   addend,
  input  logic [COST_W-1:0] acc,
  output logic [COST_W-1:0] result
);

  logic [COST_W:0]   sum;
  logic [COST_W-1:0] sat;

  always_comb begin
    sum    = {1'b0, operand} + (COST_W + 1)'(addend);
    sat    = sum[COST_W] ? {COST_W{1'b1}} : sum[COST_W-1:0];
    result = (sat < acc) ? sat : acc;
  end

endmodule

// ===== hw/rtl/banded_dtw_distance_top.sv =====
// ============================================================================
// Banded DTW distance top level
// Slope-constrained dynamic time warping between stored query and template
// pitch sequences, one cell at a time through a shared accumulate unit.
// ============================================================================
// Usage:
// The input stream carries a command in s_axis_tuser. Load commands write a
// sample into the query or template store at the given index. A compute
// command fills the banded cost matrix row by row, keeping the three newest
// rows in a cost memory, and produces one result transaction on the output
// stream: the smallest last-row cost below the sentinel, its column, and a
// found flag.
// Compute steps: the band limits are set once per row; a cell outside the
// band or on the first two rows and columns is written directly, and an
// interior cell takes a store read, a difference, then three passes through
// the accumulate unit over the single cost memory read port. A hand-over step
// then moves the result out. s_axis_tready is low for the whole computation.
// The result sits in an output register; loads are taken while it waits,
// and a later compute holds its result until that register is free.
// Reset clears the sequencer and the output valid; the stores hold no reset
// value and must be written before they are used.
// ============================================================================
module banded_dtw_distance_top import bdtw_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // index[9:0], sample[25:10], query_length[36:26], template_length[47:37]
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // command[1:0]
  input  logic [CMD_W-1:0]      s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // distance[21:0], end_position[31:22], found[32], zero padding above
  output logic [OUT_DATA_W-1:0] m_axis_tdata
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_ROW  = 3'd1;
  localparam logic [2:0] S_CELL = 3'd2;
  localparam logic [2:0] S_DIFF = 3'd3;
  localparam logic [2:0] S_ADDA = 3'd4;
  localparam logic [2:0] S_ADDB = 3'd5;
  localparam logic [2:0] S_ADDC = 3'd6;
  localparam logic [2:0] S_DONE = 3'd7;

  logic [2:0] state;

  logic [IDX_W-1:0]    in_index;
  logic [SAMPLE_W-1:0] in_sample;
  logic [LEN_W-1:0]    in_query_length;
  logic [LEN_W-1:0]    in_template_length;

  assign in_index           = s_axis_tdata[9:0];
  assign in_sample          = s_axis_tdata[25:10];
  assign in_query_length    = s_axis_tdata[36:26];
  assign in_template_length = s_axis_tdata[47:37];

  logic [SAMPLE_W-1:0] query_mem    [MAX_QUERY];
  logic [SAMPLE_W-1:0] template_mem [MAX_TEMPLATE];
  logic [COST_W-1:0]   cost_mem     [3 * MAX_TEMPLATE];

  logic [SAMPLE_W-1:0] q_rd;
  logic [SAMPLE_W-1:0] t_rd;
  logic [COST_W-1:0]   cost_rd;

  logic [QA_W-1:0]   row;
  logic [TA_W-1:0]   col;
  logic [QA_W-1:0]   row_last;
  logic [TA_W-1:0]   col_last;
  logic [1:0]        cur_sel;
  logic [QA_W-1:0]   band_lo;
  logic [TA_W-1:0]   band_hi;
  logic              band_empty;
  logic [D_W-1:0]    d;
  logic [D3_W-1:0]   d3;
  logic [COST_W-1:0] acc;
  logic [COST_W-1:0] best;
  logic [TA_W-1:0]   best_col;

  logic [DIST_W-1:0] out_dist;
  logic [POS_W-1:0]  out_pos;
  logic              out_found;

  logic s_fire;
  assign s_axis_tready = (state == S_IDLE);
  assign s_fire        = s_axis_tvalid && s_axis_tready;

  // Length saturation and load index checks.
  logic [31:0] lq_sat;
  logic [31:0] lt_sat;
  logic        q_idx_ok;
  logic        t_idx_ok;

  always_comb begin
    lq_sat = (32'(in_query_length) > 32'(MAX_QUERY)) ? 32'(MAX_QUERY)
                                                      : 32'(in_query_length);
    lt_sat = (32'(in_template_length) > 32'(MAX_TEMPLATE)) ? 32'(MAX_TEMPLATE)
                                                            : 32'(in_template_length);
    q_idx_ok = 32'(in_index) < 32'(MAX_QUERY);
    t_idx_ok = 32'(in_index) < 32'(MAX_TEMPLATE);
  end

  // Band limits for the current row.
  logic [QA_W:0]        row_inc;
  logic [HW-1:0]        hi_sum;
  logic signed [HW-1:0] hi_half;
  logic                 hi_clamp;

  always_comb begin
    row_inc  = {1'b0, row} + (QA_W + 1)'(1);
    hi_sum   = HW'(row) + (HW'(col_last) << 1) + HW'(2) - HW'(row_last);
    hi_half  = $signed(hi_sum) >>> 1;
    hi_clamp = hi_half > $signed(HW'(col_last));
  end

  // Cell classification.
  logic              in_band;
  logic              edge_cell;
  logic              simple_cell;
  logic [COST_W-1:0] simple_val;

  always_comb begin
    in_band     = !band_empty && (col <= band_hi) && (HW'(col) >= HW'(band_lo));
    edge_cell   = (row <= QA_W'(1)) || (col <= TA_W'(1));
    simple_cell = !in_band || edge_cell;
    simple_val  = in_band ? {COST_W{1'b0}} : SENTINEL;
  end

  // Rolling row selects: previous row and the one before it.
  logic [1:0] p1_sel;
  logic [1:0] p2_sel;
  assign p1_sel = (cur_sel == 2'd0) ? 2'd2 : cur_sel - 2'd1;
  assign p2_sel = (cur_sel == 2'd2) ? 2'd0 : cur_sel + 2'd1;

  function automatic logic [CA_W-1:0] cost_addr(input logic [1:0] sel,
                                                input logic [TA_W-1:0] c);
    logic [CA_W-1:0] base;
    base = CA_W'(sel) * CA_W'(MAX_TEMPLATE);
    return base + CA_W'(c);
  endfunction

  logic [CA_W-1:0] rd_addr;
  always_comb begin
    case (state)
      S_ADDA:  rd_addr = cost_addr(p1_sel, col - TA_W'(2));
      S_ADDB:  rd_addr = cost_addr(p2_sel, col - TA_W'(1));
      default: rd_addr = cost_addr(p1_sel, col - TA_W'(1));
    endcase
  end

  // Shared accumulate unit.
  logic [D3_W-1:0]   unit_addend;
  logic [COST_W-1:0] unit_acc;
  logic [COST_W-1:0] unit_out;

  assign unit_addend = (state == S_ADDA) ? D3_W'(d) : d3;
  assign unit_acc    = (state == S_ADDA) ? {COST_W{1'b1}} : acc;

  bdtw_acc_unit u_acc (
    .operand (cost_rd),
    .addend  (unit_addend),
    .acc     (unit_acc),
    .result  (unit_out)
  );

  // Cost write and best tracking.
  logic              cost_we;
  logic [COST_W-1:0] cost_wdata;
  logic              cell_done;

  assign cell_done  = ((state == S_CELL) && simple_cell) || (state == S_ADDC);
  assign cost_we    = cell_done;
  assign cost_wdata = (state == S_ADDC) ? unit_out : simple_val;

  logic [SAMPLE_W:0] diff;
  logic [SAMPLE_W:0] diff_abs;
  always_comb begin
    diff     = {q_rd[SAMPLE_W-1], q_rd} - {t_rd[SAMPLE_W-1], t_rd};
    diff_abs = diff[SAMPLE_W] ? -diff : diff;
  end

  // Memories.
  always_ff @(posedge clk) begin
    if (s_fire && (s_axis_tuser == CMD_LOAD_QUERY) && q_idx_ok) begin
      query_mem[QA_W'(in_index)] <= in_sample;
    end
    if (s_fire && (s_axis_tuser == CMD_LOAD_TEMPLATE) && t_idx_ok) begin
      template_mem[TA_W'(in_index)] <= in_sample;
    end
    q_rd <= query_mem[row];
    t_rd <= template_mem[col];
  end

  always_ff @(posedge clk) begin
    if (cost_we) begin
      cost_mem[cost_addr(cur_sel, col)] <= cost_wdata;
    end
    cost_rd <= cost_mem[rd_addr];
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      row           <= '0;
      col           <= '0;
      best          <= SENTINEL;
      best_col      <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready && (state != S_DONE)) begin
        m_axis_tvalid <= 1'b0;
      end

      if (cell_done && (row == row_last) && (cost_wdata < best)) begin
        best     <= cost_wdata;
        best_col <= col;
      end

      case (state)
        S_IDLE: begin
          if (s_fire && (s_axis_tuser == CMD_COMPUTE)) begin
            best     <= SENTINEL;
            best_col <= '0;
            row      <= '0;
            cur_sel  <= 2'd0;
            row_last <= QA_W'(lq_sat - 32'd1);
            col_last <= TA_W'(lt_sat - 32'd1);
            if ((lq_sat == 32'd0) || (lt_sat == 32'd0)) begin
              state <= S_DONE;
            end else begin
              state <= S_ROW;
            end
          end
        end
        S_ROW: begin
          band_lo    <= row_inc[QA_W:1];
          band_empty <= hi_half[HW-1];
          band_hi    <= hi_clamp ? col_last : hi_half[TA_W-1:0];
          col        <= '0;
          state      <= S_CELL;
        end
        S_CELL: begin
          if (!simple_cell) begin
            state <= S_DIFF;
          end
        end
        S_DIFF: begin
          d     <= diff_abs[D_W-1:0];
          state <= S_ADDA;
        end
        S_ADDA: begin
          d3    <= D3_W'(d) + {1'b0, d, 1'b0};
          acc   <= unit_out;
          state <= S_ADDB;
        end
        S_ADDB: begin
          acc   <= unit_out;
          state <= S_ADDC;
        end
        S_ADDC: begin
          // The cell write below moves the sequencer on.
        end
        S_DONE: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tvalid <= 1'b1;
            out_dist      <= best[DIST_W-1:0];
            out_found     <= best < SENTINEL;
            out_pos       <= (best < SENTINEL) ? POS_W'(best_col) : '0;
            state         <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase

      // Column and row advance once a cell has been written.
      if (cell_done) begin
        if (col == col_last) begin
          if (row == row_last) begin
            state <= S_DONE;
          end else begin
            row     <= row + QA_W'(1);
            cur_sel <= (cur_sel == 2'd2) ? 2'd0 : cur_sel + 2'd1;
            state   <= S_ROW;
          end
        end else begin
          col   <= col + TA_W'(1);
          state <= S_CELL;
        end
      end
    end
  end

  assign m_axis_tdata = {(OUT_DATA_W - DIST_W - POS_W - 1)'(0), out_found, out_pos, out_dist};

`ifndef SYNTHESIS
  a_cell_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_CELL) |-> ((col <= col_last) && (row <= row_last)))
    else $error("cell counters beyond the matrix");

  a_found_below_sentinel: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && out_found) |-> (32'(out_dist) < SENTINEL))
    else $error("found result at or above the sentinel");

  a_not_found_result: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !out_found) |-> ((out_pos == '0) && (32'(out_dist) == SENTINEL)))
    else $error("not-found result without sentinel distance and zero position");

  a_result_only_at_done: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> ($past(state) == S_DONE))
    else $error("result raised outside the hand-over step");
`endif

endmodule
